// ----- rtl/hrle_pkg.sv -----
// ----------------------------------------------------------------------------
// hrle_pkg
// Shared types, constants and helpers for the hex record line encoder.
// ----------------------------------------------------------------------------
package hrle_pkg;

   // record capacity in 32-bit data words
   localparam int MAX_WORDS = 16;
   localparam int WORDS_W   = $clog2(MAX_WORDS + 1);

   // item function codes
   localparam logic FUNC_HEADER = 1'b0;
   localparam logic FUNC_DATA   = 1'b1;

   // line characters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // character positions within one item's output sequence
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_COLON       = 4'd0;
   localparam logic [POS_W-1:0] POS_FIRST_DIGIT = 4'd1;
   localparam logic [POS_W-1:0] POS_LAST_DIGIT  = 4'd8;
   localparam logic [POS_W-1:0] POS_CHK_HI      = 4'd9;
   localparam logic [POS_W-1:0] POS_CHK_LO      = 4'd10;
   localparam logic [POS_W-1:0] POS_CR          = 4'd11;
   localparam logic [POS_W-1:0] POS_LF          = 4'd12;

   // map one nibble to its upper-case ASCII hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] ch;
      if (nibble < 4'd10) begin
         ch = 8'h30 + {4'h0, nibble};
      end else begin
         ch = 8'h37 + {4'h0, nibble};
      end
      return ch;
   endfunction

endpackage

// ----- rtl/hrle_req_if.sv -----
// ----------------------------------------------------------------------------
// hrle_req_if
// Input item channel: record header or data word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrle_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [6:0]  byte_count;
   logic [15:0] load_address;
   logic [3:0]  record_type;
   logic [31:0] data_word;

   modport source (output valid, output func, output byte_count, output load_address,
                   output record_type, output data_word, input ready);
   modport sink   (input valid, input func, input byte_count, input load_address,
                   input record_type, input data_word, output ready);
endinterface

// ----- rtl/hrle_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hrle_rsp_if
// Result channel: one ASCII character of the record line per transfer.
// ----------------------------------------------------------------------------
interface hrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       line_end;
   logic       item_last;

   modport source (output valid, output char_out, output line_end, output item_last,
                   input ready);
   modport sink   (input valid, input char_out, input line_end, input item_last,
                   output ready);
endinterface

// ----- rtl/hex_record_line_encoder.sv -----
// ----------------------------------------------------------------------------
// hex_record_line_encoder
// Turns header and data word items into an Intel-HEX style ASCII line.
// ----------------------------------------------------------------------------
// An accepted item's characters pass from the character job into the result register.
// One character per cycle on the result link while it is not stalled; a data item
//   gives 8 characters (12 with the checksum tail), a header 9 (13 for an empty record).
// A new item is taken in the cycle its predecessor hands over its last character.
// Reset clears the open record, the character job and the result register.
// ----------------------------------------------------------------------------
module hex_record_line_encoder (
   input  logic         clock,
   input  logic         reset,
   hrle_req_if.sink     req_chan,
   hrle_rsp_if.source   rsp_chan
);

   // record state
   logic                         in_record_ff, in_record_in;
   logic [7:0]                   byte_sum_ff, byte_sum_in;
   logic [hrle_pkg::WORDS_W-1:0] words_left_ff, words_left_in;

   // character job for the current item
   logic                         job_valid_ff, job_valid_in;
   logic [31:0]                  job_digits_ff, job_digits_in;
   logic [hrle_pkg::POS_W-1:0]   job_pos_ff, job_pos_in;
   logic                         job_tail_ff, job_tail_in;
   logic [7:0]                   job_chk_ff, job_chk_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_char_ff, rsp_char_in;
   logic                         rsp_line_end_ff, rsp_line_end_in;
   logic                         rsp_item_last_ff, rsp_item_last_in;

   logic                         req_accept;
   logic                         is_header;
   logic                         take_data;
   logic                         job_start;
   logic [hrle_pkg::WORDS_W-1:0] hdr_words;
   logic [hrle_pkg::WORDS_W-1:0] new_words;
   logic [7:0]                   new_sum;
   logic [9:0]                   hdr_sum_wide;
   logic [9:0]                   data_sum_wide;
   logic                         out_free;
   logic                         emit;
   logic [hrle_pkg::POS_W-1:0]   job_last_pos;
   logic                         job_done;
   logic [hrle_pkg::POS_W-1:0]   digit_sel;
   logic [3:0]                   digit_nibble;
   logic [7:0]                   job_char;

   // decode the incoming item
   always_comb begin
      is_header = (req_chan.func == hrle_pkg::FUNC_HEADER);
      take_data = in_record_ff && (words_left_ff != '0);

      if (int'(req_chan.byte_count[6:2]) > hrle_pkg::MAX_WORDS) begin
         hdr_words = hrle_pkg::WORDS_W'(hrle_pkg::MAX_WORDS);
      end else begin
         hdr_words = hrle_pkg::WORDS_W'(req_chan.byte_count[6:2]);
      end

      hdr_sum_wide  = {3'b000, req_chan.byte_count} + {2'b00, req_chan.load_address[7:0]}
                    + {2'b00, req_chan.load_address[15:8]} + {6'h00, req_chan.record_type};
      data_sum_wide = {2'b00, byte_sum_ff} + {2'b00, req_chan.data_word[7:0]}
                    + {2'b00, req_chan.data_word[15:8]} + {2'b00, req_chan.data_word[23:16]}
                    + {2'b00, req_chan.data_word[31:24]};

      if (is_header) begin
         new_sum   = hdr_sum_wide[7:0];
         new_words = hdr_words;
      end else begin
         new_sum   = data_sum_wide[7:0];
         new_words = words_left_ff - hrle_pkg::WORDS_W'(1);
      end
   end

   // emitter control
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_chan.ready;
      emit         = job_valid_ff && out_free;
      job_last_pos = job_tail_ff ? hrle_pkg::POS_LF : hrle_pkg::POS_LAST_DIGIT;
      job_done     = emit && (job_pos_ff == job_last_pos);
   end

   assign req_chan.ready = !job_valid_ff || job_done;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign job_start      = req_accept && (is_header || take_data);

   // update record state on every accepted item that belongs to a record
   always_comb begin
      in_record_in  = in_record_ff;
      byte_sum_in   = byte_sum_ff;
      words_left_in = words_left_ff;
      if (job_start) begin
         byte_sum_in   = new_sum;
         words_left_in = new_words;
         in_record_in  = (new_words != '0);
      end
   end

   // load, advance or drop the character job
   always_comb begin
      job_valid_in  = job_valid_ff;
      job_digits_in = job_digits_ff;
      job_pos_in    = job_pos_ff;
      job_tail_in   = job_tail_ff;
      job_chk_in    = job_chk_ff;
      if (job_start) begin
         job_valid_in = 1'b1;
         job_tail_in  = (new_words == '0);
         job_chk_in   = 8'h00 - new_sum;
         if (is_header) begin
            job_digits_in = {1'b0, req_chan.byte_count, req_chan.load_address, 4'h0,
                             req_chan.record_type};
            job_pos_in    = hrle_pkg::POS_COLON;
         end else begin
            job_digits_in = req_chan.data_word;
            job_pos_in    = hrle_pkg::POS_FIRST_DIGIT;
         end
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         job_pos_in = job_pos_ff + hrle_pkg::POS_W'(1);
      end
   end

   // select the character at the current position
   always_comb begin
      digit_sel    = hrle_pkg::POS_LAST_DIGIT - job_pos_ff;
      digit_nibble = 4'(job_digits_ff >> {digit_sel[2:0], 2'b00});
      priority if (job_pos_ff == hrle_pkg::POS_COLON) begin
         job_char = hrle_pkg::CH_COLON;
      end else if (job_pos_ff <= hrle_pkg::POS_LAST_DIGIT) begin
         job_char = hrle_pkg::hex_char(digit_nibble);
      end else if (job_pos_ff == hrle_pkg::POS_CHK_HI) begin
         job_char = hrle_pkg::hex_char(job_chk_ff[7:4]);
      end else if (job_pos_ff == hrle_pkg::POS_CHK_LO) begin
         job_char = hrle_pkg::hex_char(job_chk_ff[3:0]);
      end else if (job_pos_ff == hrle_pkg::POS_CR) begin
         job_char = hrle_pkg::CH_CR;
      end else begin
         job_char = hrle_pkg::CH_LF;
      end
   end

   // fill the result register whenever it is free
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_char_in      = rsp_char_ff;
      rsp_line_end_in  = rsp_line_end_ff;
      rsp_item_last_in = rsp_item_last_ff;
      if (out_free) begin
         rsp_valid_in     = emit;
         rsp_char_in      = job_char;
         rsp_line_end_in  = (job_pos_ff == hrle_pkg::POS_LF);
         rsp_item_last_in = (job_pos_ff == job_last_pos);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_record_ff  <= 1'b0;
         byte_sum_ff   <= 8'h00;
         words_left_ff <= '0;
         job_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_record_ff  <= in_record_in;
         byte_sum_ff   <= byte_sum_in;
         words_left_ff <= words_left_in;
         job_valid_ff  <= job_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_digits_ff    <= job_digits_in;
      job_pos_ff       <= job_pos_in;
      job_tail_ff      <= job_tail_in;
      job_chk_ff       <= job_chk_in;
      rsp_char_ff      <= rsp_char_in;
      rsp_line_end_ff  <= rsp_line_end_in;
      rsp_item_last_ff <= rsp_item_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.char_out  = rsp_char_ff;
   assign rsp_chan.line_end  = rsp_line_end_ff;
   assign rsp_chan.item_last = rsp_item_last_ff;

endmodule

// ----- rtl/hrle_checker.sv -----
// ----------------------------------------------------------------------------
// hrle_checker
// Port-level checks for the hex record line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hrle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_out,
   input logic       rsp_line_end,
   input logic       rsp_item_last
);

   // result link comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out))
      else $error("stalled result changed");

   // line end is always the LF that closes its item
   a_line_end_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_char_out == hrle_pkg::CH_LF && rsp_item_last)
      else $error("line end not on a closing LF");

   // a colon always has a header's digits after it
   a_colon_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_out == hrle_pkg::CH_COLON |-> !rsp_item_last)
      else $error("colon marked as last character");

endmodule

bind hex_record_line_encoder hrle_checker u_hrle_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_char_out  (rsp_chan.char_out),
   .rsp_line_end  (rsp_chan.line_end),
   .rsp_item_last (rsp_chan.item_last)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex record line encoder. Header and data word
// items go in; every ASCII character that comes out is checked against a
// line predicted in the bench, including the checksum and the line end.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // one expected character of a record line
   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
      logic       item_last;
   } line_char_type;

   logic clock;
   logic reset;

   hrle_req_if req_if ();
   hrle_rsp_if rsp_if ();

   hex_record_line_encoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predicted characters, oldest first
   line_char_type expected_chars_q[$];
   line_char_type want_char;
   int            mismatch_count = 0;

   // predicted record state
   logic [7:0] rec_sum;
   logic [4:0] rec_words_left;
   logic       rec_open;

   // idling controls
   bit req_gaps_on   = 1'b0;
   bit rsp_stalls_on = 1'b0;
   int rsp_hold_req  = 0;
   int rsp_stall_left = 0;

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // give up after a generous fixed time
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Line prediction
   // ------------------------------------------------------------------------

   function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end
      return 8'h41 + {4'h0, nib} - 8'd10;
   endfunction

   function automatic void push_char(input logic [7:0] ch, input logic lend);
      line_char_type c;
      c.ch        = ch;
      c.line_end  = lend;
      c.item_last = 1'b0;
      expected_chars_q.push_back(c);
   endfunction

   // push n hex digits of v, most significant first
   function automatic void push_digits(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         push_char(nibble_ascii(v[4*i +: 4]), 1'b0);
      end
   endfunction

   // checksum, CR, LF; close the record
   function automatic void close_line();
      logic [7:0] chk;
      chk = 8'h00 - rec_sum;
      push_digits({24'h0, chk}, 2);
      push_char(hrle_pkg::CH_CR, 1'b0);
      push_char(hrle_pkg::CH_LF, 1'b1);
      rec_open       = 1'b0;
      rec_words_left = '0;
   endfunction

   function automatic void predict_line_chars(input logic f, input logic [6:0] cnt,
                                              input logic [15:0] addr, input logic [3:0] typ,
                                              input logic [31:0] word);
      int            n0;
      int            nwords;
      line_char_type c;
      n0 = expected_chars_q.size();
      if (f == hrle_pkg::FUNC_HEADER) begin
         rec_sum = {1'b0, cnt} + addr[7:0] + addr[15:8] + {4'h0, typ};
         nwords  = int'(cnt) >> 2;
         if (nwords > hrle_pkg::MAX_WORDS) begin
            nwords = hrle_pkg::MAX_WORDS;
         end
         rec_words_left = nwords[4:0];
         rec_open       = 1'b1;
         push_char(hrle_pkg::CH_COLON, 1'b0);
         push_digits({25'h0, cnt}, 2);
         push_digits({16'h0, addr}, 4);
         push_digits({28'h0, typ}, 2);
         if (rec_words_left == 0) begin
            close_line();
         end
      end else if (rec_open && rec_words_left != 0) begin
         rec_sum = rec_sum + word[7:0] + word[15:8] + word[23:16] + word[31:24];
         push_digits(word, 8);
         rec_words_left = rec_words_left - 5'd1;
         if (rec_words_left == 0) begin
            close_line();
         end
      end
      // flag the last character of this item
      if (expected_chars_q.size() > n0) begin
         c = expected_chars_q.pop_back();
         c.item_last = 1'b1;
         expected_chars_q.push_back(c);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result side: stall control and checking
   // ------------------------------------------------------------------------

   // drive ready: a requested long hold-off, else random stall bursts
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_req--;
         end else if (rsp_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // compare each accepted character with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_chars_q.size() == 0) begin
            $display("%0t ERROR unexpected char: expected none, actual %h",
                     $time, rsp_if.char_out);
            mismatch_count++;
         end else begin
            want_char = expected_chars_q.pop_front();
            if (rsp_if.char_out !== want_char.ch) begin
               $display("%0t ERROR char_out: expected %h, actual %h",
                        $time, want_char.ch, rsp_if.char_out);
               mismatch_count++;
            end
            if (rsp_if.line_end !== want_char.line_end) begin
               $display("%0t ERROR line_end: expected %b, actual %b",
                        $time, want_char.line_end, rsp_if.line_end);
               mismatch_count++;
            end
            if (rsp_if.item_last !== want_char.item_last) begin
               $display("%0t ERROR item_last: expected %b, actual %b",
                        $time, want_char.item_last, rsp_if.item_last);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   // offer one item from a falling edge, hold it until accepted, predict it
   task automatic send_item(input logic f, input logic [6:0] cnt, input logic [15:0] addr,
                            input logic [3:0] typ, input logic [31:0] word);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= f;
      req_if.byte_count   <= cnt;
      req_if.load_address <= addr;
      req_if.record_type  <= typ;
      req_if.data_word    <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_line_chars(f, cnt, addr, typ, word);
      @(negedge clock);
   endtask

   // unused fields carry random values
   task automatic send_header(input int cnt, input int addr, input int typ);
      send_item(hrle_pkg::FUNC_HEADER, cnt[6:0], addr[15:0], typ[3:0], $urandom);
   endtask

   task automatic send_word(input logic [31:0] word);
      send_item(hrle_pkg::FUNC_DATA, 7'($urandom_range(0, 127)),
                16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), word);
   endtask

   // stop offering, then wait until every predicted character has come out
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (expected_chars_q.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // field extremes and each corner of the record format
   task automatic test_directed_cases();
      // empty records: zero checksum, then all-ones address and type
      send_header(0, 16'h0000, 4'h0);
      send_header(0, 16'hFFFF, 4'hF);
      // data with no open record: ignored
      send_word(32'hDEADBEEF);
      send_header(4, 16'h1234, 4'h1);
      send_word(32'hFFFFFFFF);
      // word beyond the count: ignored
      send_word(32'h00000000);
      // count not a multiple of four: rounds down to one word
      send_header(6, 16'h00A0, 4'h0);
      send_word(32'h89ABCDEF);
      // count below four: no words at all
      send_header(3, 16'h0001, 4'h2);
      // abandon an open record twice
      send_header(8, 16'hABCD, 4'h4);
      send_word(32'h12345678);
      send_header(12, 16'h00FF, 4'h3);
      send_word(32'h0F0F0F0F);
      send_word(32'hF0F0F0F0);
      send_header(0, 16'h5A5A, 4'hA);
      // large byte sum that wraps several times
      send_header(16, 16'hFFFF, 4'hF);
      repeat (4) send_word(32'hFFFFFFFF);
   endtask

   // count above capacity: words saturate, digits keep the given count
   task automatic test_over_capacity();
      send_header(127, 16'h8000, 4'h5);
      repeat (16) send_word($urandom);
      send_word($urandom);
   endtask

   // hold the result side off so the block fills and stalls its input
   task automatic test_back_pressure();
      wait_results_drained();
      rsp_hold_req = 200;
      send_header(64, $urandom_range(0, 65535), $urandom_range(0, 15));
      repeat (16) send_word($urandom);
      // pause the input until every character has come out
      wait_results_drained();
   endtask

   // mostly well-formed records with random content, some noise and cut records
   task automatic test_random_records(input int n_items);
      int sent;
      int cnt;
      int nwords;
      int cut;
      int pick;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 8) begin
            send_word($urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               cnt = 4 * $urandom_range(0, 4);
            end else if (pick < 75) begin
               cnt = 4 * $urandom_range(5, 16);
            end else if (pick < 90) begin
               cnt = $urandom_range(0, 64);
            end else begin
               cnt = $urandom_range(65, 127);
            end
            nwords = cnt / 4;
            if (nwords > hrle_pkg::MAX_WORDS) begin
               nwords = hrle_pkg::MAX_WORDS;
            end
            cut = nwords;
            if (nwords > 0 && $urandom_range(0, 9) == 0) begin
               cut = $urandom_range(0, nwords - 1);
            end
            send_header(cnt, $urandom_range(0, 65535), $urandom_range(0, 15));
            sent++;
            for (int k = 0; k < cut; k++) begin
               send_word($urandom);
               sent++;
            end
            if (cut == nwords && $urandom_range(0, 7) == 0) begin
               send_word($urandom);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.func         = hrle_pkg::FUNC_HEADER;
      req_if.byte_count   = '0;
      req_if.load_address = '0;
      req_if.record_type  = '0;
      req_if.data_word    = '0;
      rec_sum             = '0;
      rec_words_left      = '0;
      rec_open            = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_directed_cases();
      test_over_capacity();
      test_back_pressure();
      test_random_records(260);

      // last part runs with no idling
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_records(60);

      wait_results_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_chars_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
